/* rtl/tcp_accecn_flow_tracker_defines.svh */
// Assertion macros shared by the flow tracker modules.
`ifndef TCP_ACCECN_FLOW_TRACKER_DEFINES_SVH
`define TCP_ACCECN_FLOW_TRACKER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ACNFT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error("flow tracker assertion failed");
`define ACNFT_NEVER(label, expr) `ACNFT_ASSERT(label, !(expr))
`else
`define ACNFT_ASSERT(label, prop)
`define ACNFT_NEVER(label, expr)
`endif
`endif

/* rtl/acnft_pkg.sv */
// Shared types, constants and helpers of the AccECN flow tracker.
package acnft_pkg;
   localparam int TABLE_ENTRIES = 128;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;

   localparam logic CMD_INGRESS = 1'b0;
   localparam logic CMD_EGRESS = 1'b1;

   localparam logic [1:0] ECN_ECT1 = 2'd1;
   localparam logic [1:0] ECN_ECT0 = 2'd2;
   localparam logic [1:0] ECN_CE = 2'd3;

   localparam logic [2:0] ACE_SYN_REQ = 3'd7;
   localparam logic [2:0] ACE_INIT_CE = 3'b110;
   localparam logic [2:0] ACE_INIT_NO_CE = 3'b101;
   localparam logic [2:0] ACE_OPEN_ECT0 = 3'd2;
   localparam logic [2:0] ACE_OPEN_ECT1 = 3'd3;
   localparam logic [2:0] ACE_OPEN_NOT_ECT = 3'd4;
   localparam logic [2:0] ACE_OPEN_CE = 3'd6;

   localparam logic [15:0] MSS_ABSENT = 16'h0000;
   localparam logic [15:0] MSS_ALL_ONES = 16'hFFFF;

   typedef struct packed {
      logic        cmd;
      logic [31:0] key;
      logic        bypass;
      logic        opens;
      logic        finrst;
      logic [1:0]  ecn;
      logic        ace_is_req;
      logic [15:0] pay;
      logic [15:0] mss;
      logic        opt;
   } req_item_type;

   typedef struct packed {
      logic [31:0] key;
      logic [2:0]  ce_cnt;
      logic [15:0] mss;
      logic        has_bytes;
      logic [23:0] ect0_bytes;
      logic [23:0] ce_bytes;
      logic [23:0] ect1_bytes;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_RANK, ST_FIN
   } back_state_type;

   typedef enum logic [1:0] {
      OP_NONE, OP_CLAIM, OP_PROMOTE, OP_DROP
   } rank_op_type;

   function automatic logic ace_opens(input logic [2:0] ace);
      logic r;
      r = (ace == ACE_OPEN_ECT0) || (ace == ACE_OPEN_ECT1) ||
          (ace == ACE_OPEN_NOT_ECT) || (ace == ACE_OPEN_CE);
      return r;
   endfunction
endpackage

/* rtl/acnft_ram.sv */
// Generic single write port RAM with registered read.
module acnft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/acnft_div.sv */
// Iterative 16-bit restoring divider, one quotient bit per cycle.
module acnft_div import acnft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [16:0] shifted;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[15:0], quo_ff[15]};
      if (start) begin
         rem_in = 17'd0;
         quo_in = dividend;
         dvs_in = divisor;
         step_in = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[14:0], 1'b0};
         end
         step_in = step_ff - 5'd1;
         busy_in = (step_ff != 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/acnft_front.sv */
// Front end: accepts requests, classifies them and queues them.
`include "tcp_accecn_flow_tracker_defines.svh"
module acnft_front import acnft_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic         req_cmd,
   input  logic [15:0]  req_src_port,
   input  logic [15:0]  req_dst_port,
   input  logic         req_syn_flag,
   input  logic         req_ack_flag,
   input  logic         req_fin_or_rst,
   input  logic [1:0]   req_ip_ecn,
   input  logic [2:0]   req_ace_bits,
   input  logic [15:0]  req_payload_bytes,
   input  logic [15:0]  req_mss_option,
   input  logic         req_accecn_option_seen,
   input  logic         pop,
   output logic         head_valid,
   output req_item_type head_item
);
   req_item_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   req_item_type item;
   logic         push;

   always_comb begin
      item.cmd = req_cmd;
      item.key = (req_cmd == CMD_INGRESS) ? {req_src_port, req_dst_port}
                                          : {req_dst_port, req_src_port};
      item.bypass = (req_cmd == CMD_EGRESS) && req_syn_flag && !req_ack_flag;
      item.opens = req_syn_flag && req_ack_flag && ace_opens(req_ace_bits);
      item.finrst = req_fin_or_rst;
      item.ecn = req_ip_ecn;
      item.ace_is_req = (req_ace_bits == ACE_SYN_REQ);
      item.pay = req_payload_bytes;
      item.mss = req_mss_option;
      item.opt = req_accecn_option_seen;
   end

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;
   assign head_valid = (count_ff != 2'd0);
   assign head_item = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   `ACNFT_NEVER(a_count_range, count_ff == 2'd3)
   `ACNFT_NEVER(a_pop_empty, pop && (count_ff == 2'd0))
endmodule

/* rtl/acnft_back.sv */
// Back end: table scan, recency update, counter update and result.
`include "tcp_accecn_flow_tracker_defines.svh"
module acnft_back import acnft_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  req_item_type head_item,
   output logic         pop,
   output logic         rsp_valid,
   output logic         rsp_rewrite_ace,
   output logic [2:0]   rsp_new_ace,
   output logic         rsp_set_ect1,
   output logic         rsp_option_update,
   output logic [23:0]  rsp_ect0_byte_count,
   output logic [23:0]  rsp_ce_byte_count,
   output logic [23:0]  rsp_ect1_byte_count,
   output logic [31:0]  rsp_accepted_flow_total
);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] RANK_OLDEST = IDX_W'(TABLE_ENTRIES - 1);

   back_state_type state_ff, state_in;
   rank_op_type    op_ff, op_in;
   req_item_type   item_ff, item_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic           chk_ff, chk_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic           hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] hit_rank_ff, hit_rank_in;
   entry_type      hit_data_ff, hit_data_in;
   logic           free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] old_idx_ff, old_idx_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic           use_div_ff, use_div_in;
   logic [31:0]    flow_total_ff, flow_total_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_rw_ff, rsp_rw_in;
   logic [2:0]     rsp_ace_ff, rsp_ace_in;
   logic           rsp_ect1_ff, rsp_ect1_in;
   logic           rsp_upd_ff, rsp_upd_in;
   logic [23:0]    rsp_e0_ff, rsp_e0_in;
   logic [23:0]    rsp_ce_ff, rsp_ce_in;
   logic [23:0]    rsp_e1_ff, rsp_e1_in;
   logic [31:0]    rsp_total_ff, rsp_total_in;

   logic [ENTRY_W-1:0] data_rd;
   entry_type      data_rd_e;
   entry_type      data_wr;
   logic           data_we;
   logic [IDX_W-1:0] rank_rd;
   logic [IDX_W-1:0] rank_new;
   logic           rank_we;
   logic           div_start, div_busy;
   logic [15:0]    div_q;
   logic [2:0]     ce_add;
   logic           mss_usable;

   acnft_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_data_ram (
      .clock(clock), .we(data_we), .waddr(slot_ff), .wdata(data_wr),
      .raddr(cnt_ff[IDX_W-1:0]), .rdata(data_rd)
   );

   acnft_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_rank_ram (
      .clock(clock), .we(rank_we), .waddr(chk_idx_ff), .wdata(rank_new),
      .raddr(cnt_ff[IDX_W-1:0]), .rdata(rank_rd)
   );

   acnft_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(item_ff.pay), .divisor(hit_data_ff.mss),
      .busy(div_busy), .quotient(div_q)
   );

   assign data_rd_e = entry_type'(data_rd);
   assign mss_usable = (hit_data_ff.mss != MSS_ABSENT) && (hit_data_ff.mss != MSS_ALL_ONES);
   assign rank_we = (state_ff == ST_RANK) && chk_ff;

   // new rank of the entry being swept
   always_comb begin
      rank_new = rank_rd;
      if (chk_idx_ff == slot_ff) begin
         rank_new = '0;
      end else if (valid_ff[chk_idx_ff]) begin
         case (op_ff)
            OP_CLAIM: rank_new = rank_rd + IDX_W'(1);
            OP_PROMOTE: begin
               if (rank_rd < hit_rank_ff) begin
                  rank_new = rank_rd + IDX_W'(1);
               end
            end
            OP_DROP: begin
               if (rank_rd > hit_rank_ff) begin
                  rank_new = rank_rd - IDX_W'(1);
               end
            end
            default: rank_new = rank_rd;
         endcase
      end
   end

   assign ce_add = use_div_ff ? (div_q[2:0] + 3'd1) : 3'd1;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      item_in = item_ff;
      cnt_in = cnt_ff;
      chk_in = 1'b0;
      chk_idx_in = cnt_ff[IDX_W-1:0];
      valid_in = valid_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_rank_in = hit_rank_ff;
      hit_data_in = hit_data_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      old_idx_in = old_idx_ff;
      slot_in = slot_ff;
      use_div_in = use_div_ff;
      flow_total_in = flow_total_ff;
      rsp_valid_in = 1'b0;
      rsp_rw_in = rsp_rw_ff;
      rsp_ace_in = rsp_ace_ff;
      rsp_ect1_in = rsp_ect1_ff;
      rsp_upd_in = rsp_upd_ff;
      rsp_e0_in = rsp_e0_ff;
      rsp_ce_in = rsp_ce_ff;
      rsp_e1_in = rsp_e1_ff;
      rsp_total_in = rsp_total_ff;
      pop = 1'b0;
      div_start = 1'b0;
      data_we = 1'b0;
      data_wr = hit_data_ff;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               item_in = head_item;
               cnt_in = '0;
               hit_in = 1'b0;
               free_in = 1'b0;
               op_in = OP_NONE;
               use_div_in = 1'b0;
               state_in = head_item.bypass ? ST_FIN : ST_SCAN;
            end
         end
         ST_SCAN, ST_RANK: begin
            if (cnt_ff != CNT_END) begin
               cnt_in = cnt_ff + CNT_W'(1);
               chk_in = 1'b1;
            end
            if ((state_ff == ST_SCAN) && chk_ff) begin
               // note first match, first free slot and the oldest entry
               if (valid_ff[chk_idx_ff] && (data_rd_e.key == item_ff.key) && !hit_ff) begin
                  hit_in = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_rank_in = rank_rd;
                  hit_data_in = data_rd_e;
               end
               if (!valid_ff[chk_idx_ff] && !free_ff) begin
                  free_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (valid_ff[chk_idx_ff] && (rank_rd == RANK_OLDEST)) begin
                  old_idx_in = chk_idx_ff;
               end
            end
            if (cnt_ff == CNT_END) begin
               state_in = (state_ff == ST_SCAN) ? ST_DECIDE : ST_FIN;
            end
         end
         ST_DECIDE: begin
            cnt_in = '0;
            slot_in = hit_idx_ff;
            op_in = OP_NONE;
            if (item_ff.cmd == CMD_INGRESS) begin
               if (hit_ff && item_ff.finrst) begin
                  op_in = OP_DROP;
               end else if (hit_ff) begin
                  op_in = OP_PROMOTE;
                  if ((item_ff.ecn == ECN_CE) && mss_usable) begin
                     div_start = 1'b1;
                     use_div_in = 1'b1;
                  end
               end else if (item_ff.opens) begin
                  op_in = OP_CLAIM;
                  slot_in = free_ff ? free_idx_ff : old_idx_ff;
               end
            end else if (hit_ff) begin
               op_in = OP_PROMOTE;
            end
            state_in = (op_in == OP_NONE) ? ST_FIN : ST_RANK;
         end
         ST_FIN: begin
            if (!div_busy) begin
               rsp_valid_in = 1'b1;
               rsp_rw_in = 1'b0;
               rsp_ace_in = 3'd0;
               rsp_ect1_in = 1'b0;
               rsp_upd_in = 1'b0;
               rsp_e0_in = 24'd0;
               rsp_ce_in = 24'd0;
               rsp_e1_in = 24'd0;
               if (item_ff.bypass) begin
                  if (!item_ff.ace_is_req) begin
                     rsp_rw_in = 1'b1;
                     rsp_ace_in = ACE_SYN_REQ;
                  end
               end else if (item_ff.cmd == CMD_EGRESS) begin
                  if (op_ff == OP_PROMOTE) begin
                     rsp_rw_in = 1'b1;
                     rsp_ace_in = hit_data_ff.ce_cnt;
                     rsp_ect1_in = 1'b1;
                     if (hit_data_ff.has_bytes && item_ff.opt) begin
                        rsp_upd_in = 1'b1;
                        rsp_e0_in = hit_data_ff.ect0_bytes;
                        rsp_ce_in = hit_data_ff.ce_bytes;
                        rsp_e1_in = hit_data_ff.ect1_bytes;
                     end
                  end
               end else begin
                  case (op_ff)
                     OP_CLAIM: begin
                        data_wr.key = item_ff.key;
                        data_wr.ce_cnt = (item_ff.ecn == ECN_CE) ? ACE_INIT_CE
                                                                  : ACE_INIT_NO_CE;
                        data_wr.mss = item_ff.mss;
                        data_wr.has_bytes = item_ff.opt;
                        data_wr.ect0_bytes = 24'd1;
                        data_wr.ce_bytes = 24'd0;
                        data_wr.ect1_bytes = 24'd1;
                        data_we = 1'b1;
                        valid_in[slot_ff] = 1'b1;
                        flow_total_in = flow_total_ff + 32'd1;
                     end
                     OP_PROMOTE: begin
                        if (item_ff.ecn == ECN_CE) begin
                           data_wr.ce_cnt = hit_data_ff.ce_cnt + ce_add;
                        end
                        if (hit_data_ff.has_bytes) begin
                           if (item_ff.ecn == ECN_CE) begin
                              data_wr.ce_bytes = hit_data_ff.ce_bytes + {8'd0, item_ff.pay};
                           end else if (item_ff.ecn == ECN_ECT0) begin
                              data_wr.ect0_bytes = hit_data_ff.ect0_bytes + {8'd0, item_ff.pay};
                           end else if (item_ff.ecn == ECN_ECT1) begin
                              data_wr.ect1_bytes = hit_data_ff.ect1_bytes + {8'd0, item_ff.pay};
                           end
                        end
                        data_we = 1'b1;
                     end
                     OP_DROP: valid_in[slot_ff] = 1'b0;
                     default: data_we = 1'b0;
                  endcase
               end
               rsp_total_in = flow_total_in;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_NONE;
         valid_ff <= '0;
         flow_total_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
         chk_ff <= 1'b0;
         cnt_ff <= '0;
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
         use_div_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         valid_ff <= valid_in;
         flow_total_ff <= flow_total_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff <= chk_in;
         cnt_ff <= cnt_in;
         hit_ff <= hit_in;
         free_ff <= free_in;
         use_div_ff <= use_div_in;
      end
      item_ff <= item_in;
      chk_idx_ff <= chk_idx_in;
      hit_idx_ff <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      hit_data_ff <= hit_data_in;
      free_idx_ff <= free_idx_in;
      old_idx_ff <= old_idx_in;
      slot_ff <= slot_in;
      rsp_rw_ff <= rsp_rw_in;
      rsp_ace_ff <= rsp_ace_in;
      rsp_ect1_ff <= rsp_ect1_in;
      rsp_upd_ff <= rsp_upd_in;
      rsp_e0_ff <= rsp_e0_in;
      rsp_ce_ff <= rsp_ce_in;
      rsp_e1_ff <= rsp_e1_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rewrite_ace = rsp_rw_ff;
   assign rsp_new_ace = rsp_ace_ff;
   assign rsp_set_ect1 = rsp_ect1_ff;
   assign rsp_option_update = rsp_upd_ff;
   assign rsp_ect0_byte_count = rsp_e0_ff;
   assign rsp_ce_byte_count = rsp_ce_ff;
   assign rsp_ect1_byte_count = rsp_e1_ff;
   assign rsp_accepted_flow_total = rsp_total_ff;

   `ACNFT_ASSERT(a_rsp_pulse, rsp_valid_ff |=> !rsp_valid_ff)
   `ACNFT_ASSERT(a_total_step, (flow_total_ff != $past(flow_total_ff)) |-> (flow_total_ff == 32'($past(flow_total_ff) + 32'd1)))
   `ACNFT_NEVER(a_div_outside_fin, div_busy && (state_ff == ST_IDLE))
endmodule

/* rtl/tcp_accecn_flow_tracker.sv */
// Top level of the AccECN flow tracker: front queue and table engine.
// Steps: an egress SYN goes from idle straight to the result state; a packet that leaves the
// table alone passes through one search sweep and the decide state; one that opens, closes
// or re-ranks an entry also takes a re-rank sweep before the result: one sweep to search, one to re-rank.
// The engine holds one request at a time; a two-deep queue takes requests meanwhile and busy
// is raised while it is full. Results cannot be stalled. Reset is synchronous and active high.
`include "tcp_accecn_flow_tracker_defines.svh"
module tcp_accecn_flow_tracker import acnft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic        req_syn_flag,
   input  logic        req_ack_flag,
   input  logic        req_fin_or_rst,
   input  logic [1:0]  req_ip_ecn,
   input  logic [2:0]  req_ace_bits,
   input  logic [15:0] req_payload_bytes,
   input  logic [15:0] req_mss_option,
   input  logic        req_accecn_option_seen,
   output logic        rsp_valid,
   output logic        rsp_rewrite_ace,
   output logic [2:0]  rsp_new_ace,
   output logic        rsp_set_ect1,
   output logic        rsp_option_update,
   output logic [23:0] rsp_ect0_byte_count,
   output logic [23:0] rsp_ce_byte_count,
   output logic [23:0] rsp_ect1_byte_count,
   output logic [31:0] rsp_accepted_flow_total
);
   // reset clears valid bits, queue, flow total and control state

   // classified request waiting at the queue head
   logic         head_valid;
   req_item_type head_item;
   logic         pop;

   // accept, classify and hold requests
   acnft_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_src_port(req_src_port), .req_dst_port(req_dst_port),
      .req_syn_flag(req_syn_flag), .req_ack_flag(req_ack_flag),
      .req_fin_or_rst(req_fin_or_rst), .req_ip_ecn(req_ip_ecn),
      .req_ace_bits(req_ace_bits), .req_payload_bytes(req_payload_bytes),
      .req_mss_option(req_mss_option),
      .req_accecn_option_seen(req_accecn_option_seen),
      .pop(pop), .head_valid(head_valid), .head_item(head_item)
   );

   // search the table, re-rank it, update counters and answer
   acnft_back u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid), .head_item(head_item),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_rewrite_ace(rsp_rewrite_ace),
      .rsp_new_ace(rsp_new_ace), .rsp_set_ect1(rsp_set_ect1),
      .rsp_option_update(rsp_option_update),
      .rsp_ect0_byte_count(rsp_ect0_byte_count),
      .rsp_ce_byte_count(rsp_ce_byte_count),
      .rsp_ect1_byte_count(rsp_ect1_byte_count),
      .rsp_accepted_flow_total(rsp_accepted_flow_total)
   );

   // never pop what is not there
   `ACNFT_NEVER(a_pop_needs_head, pop && !head_valid)
endmodule
